>>> rtl/core/pae_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and codes for the positional array engine.
// Depends on nothing; the interfaces, front end, back end and top level import it.
package pae_pkg;

    // Field widths of the command and response channels.
    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 6;
    localparam int COUNT_W = 7;

    // Default number of array entries.
    localparam int DEPTH_DEFAULT = 64;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    // Response status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // Work handed from the front end to the back end. A rejected request
    // travels as OP_NONE and only reports its status.
    localparam int OP_W = 3;
    typedef enum logic [OP_W-1:0] {
        OP_NONE   = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_READ   = 3'd4
    } t_op;

endpackage

>>> rtl/core/pae_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on pae_pkg for the field widths.
interface pae_cmd_if import pae_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [POS_W-1:0]    position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

interface pae_rsp_if import pae_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [FOUND_W-1:0]   found_index;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]   element_count;

    modport source (output valid, output status, output found_index,
                    output read_value, output element_count, input ready);
    modport sink   (input valid, input status, input found_index,
                    input read_value, input element_count, output ready);
endinterface

>>> rtl/core/pae_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module pae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pae_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, checks positions against the projected element
// count and emits one job per request. Depends on pae_pkg and pae_if.
module pae_front import pae_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEFAULT,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int JOB_W = OP_W + STAT_W + AW + 2 * CW + DATA_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pae_cmd_if.sink          i_cmd,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output logic [JOB_W-1:0] o_job
);

    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    typedef struct packed {
        t_op               op;
        logic [STAT_W-1:0] status;
        logic [AW-1:0]     pos;
        logic [CW-1:0]     cnt_old;
        logic [CW-1:0]     cnt_new;
        logic [DATA_W-1:0] value;
    } t_job;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             push;
    t_job             job;

    assign pos_x = CMP_W'(i_cmd.position);
    assign cnt_x = CMP_W'(r_count);
    assign push  = i_cmd.valid && i_job_ready;

    always_comb begin
        job         = '0;
        job.pos     = AW'(pos_x);
        job.cnt_old = r_count;
        job.value   = i_cmd.value;
        job.status  = ST_OK;
        job.op      = OP_NONE;
        n_count     = r_count;
        unique case (i_cmd.command)
            CMD_INSERT: begin
                if (pos_x > cnt_x) begin
                    job.status = ST_BAD_POS;
                end else if (r_count >= CW'(DEPTH)) begin
                    job.status = ST_FULL;
                end else begin
                    job.op  = OP_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (pos_x >= cnt_x) begin
                    job.status = ST_BAD_POS;
                end else begin
                    job.op  = OP_DELETE;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_SEARCH: begin
                job.op = OP_SEARCH;
            end
            CMD_READ: begin
                if (pos_x >= cnt_x) begin
                    job.status = ST_BAD_POS;
                end else begin
                    job.op = OP_READ;
                end
            end
            default: begin
                job.op = OP_NONE;
            end
        endcase
        job.cnt_new = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (push) begin
            r_count <= n_count;
        end
    end

    assign i_cmd.ready = i_job_ready;
    assign o_job_valid = i_cmd.valid;
    assign o_job       = job;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count exceeds the array depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && job.op == OP_INSERT |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("accepted insert did not grow the element count");

endmodule

>>> rtl/core/pae_fifo.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the back end.
// Depends on nothing.
module pae_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_fill;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> rtl/core/pae_back.sv
`timescale 1ns / 1ps
// Back end: walks the element RAM one entry per cycle to shift, search or
// read, and holds the response in an output register. Depends on pae_pkg, pae_if.
module pae_back import pae_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEFAULT,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int JOB_W = OP_W + STAT_W + AW + 2 * CW + DATA_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    input  logic [JOB_W-1:0]  i_job,
    output logic              o_ram_we,
    output logic [AW-1:0]     o_ram_waddr,
    output logic [DATA_W-1:0] o_ram_wdata,
    output logic              o_ram_re,
    output logic [AW-1:0]     o_ram_raddr,
    input  logic [DATA_W-1:0] i_ram_rdata,
    pae_rsp_if.source         o_rsp
);

    typedef struct packed {
        t_op               op;
        logic [STAT_W-1:0] status;
        logic [AW-1:0]     pos;
        logic [CW-1:0]     cnt_old;
        logic [CW-1:0]     cnt_new;
        logic [DATA_W-1:0] value;
    } t_job;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic              r_state;
    t_job              r_job;
    t_job              in_job;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_left;
    logic              r_vld;
    logic [AW-1:0]     r_vidx;
    logic              r_out_vld;
    logic [STAT_W-1:0] r_out_status;
    logic [FOUND_W-1:0] r_out_found;
    logic [DATA_W-1:0] r_out_rd;
    logic [COUNT_W-1:0] r_out_count;

    logic              pop;
    logic              rd_en;
    logic              hit;
    logic              shift_wr;
    logic              done_idle;
    logic              final_wr;
    logic              finish;
    logic [AW-1:0]     n_rd_ptr;
    logic [CW-1:0]     n_left;

    assign in_job = t_job'(i_job);
    assign pop    = (r_state == S_IDLE) && i_job_valid && (!r_out_vld || o_rsp.ready);

    // Start pointer and number of reads for a new job.
    always_comb begin
        n_rd_ptr = '0;
        n_left   = '0;
        unique case (in_job.op)
            OP_INSERT: begin
                n_rd_ptr = AW'(in_job.cnt_old - 1'b1);
                n_left   = in_job.cnt_old - CW'(in_job.pos);
            end
            OP_DELETE: begin
                n_rd_ptr = in_job.pos + 1'b1;
                n_left   = in_job.cnt_old - CW'(in_job.pos) - 1'b1;
            end
            OP_SEARCH: begin
                n_rd_ptr = '0;
                n_left   = in_job.cnt_old;
            end
            OP_READ: begin
                n_rd_ptr = in_job.pos;
                n_left   = CW'(1);
            end
            default: begin
                n_rd_ptr = '0;
                n_left   = '0;
            end
        endcase
    end

    assign rd_en     = (r_state == S_RUN) && (r_left != '0);
    assign hit       = r_vld && ((r_job.op == OP_SEARCH && i_ram_rdata == r_job.value)
                                 || r_job.op == OP_READ);
    assign shift_wr  = r_vld && (r_job.op == OP_INSERT || r_job.op == OP_DELETE);
    assign done_idle = (r_state == S_RUN) && !r_vld && (r_left == '0);
    assign final_wr  = done_idle && (r_job.op == OP_INSERT);
    assign finish    = (r_state == S_RUN) && (hit || done_idle);

    assign o_ram_re    = rd_en;
    assign o_ram_raddr = r_rd_ptr;
    assign o_ram_we    = shift_wr || final_wr;
    assign o_ram_waddr = final_wr ? r_job.pos :
                         (r_job.op == OP_INSERT) ? r_vidx + 1'b1 : r_vidx - 1'b1;
    assign o_ram_wdata = final_wr ? r_job.value : i_ram_rdata;
    assign o_job_pop   = pop;

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= in_job;
        end
        if (finish) begin
            r_out_status <= (r_job.op == OP_SEARCH && !hit) ? ST_NOTFOUND : r_job.status;
            r_out_found  <= (r_job.op == OP_SEARCH && hit) ? FOUND_W'(r_vidx) : '0;
            r_out_rd     <= (r_job.op == OP_READ && hit) ? i_ram_rdata : '0;
            r_out_count  <= COUNT_W'(r_job.cnt_new);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_ptr  <= '0;
            r_left    <= '0;
            r_vld     <= 1'b0;
            r_vidx    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_state  <= S_RUN;
                        r_rd_ptr <= n_rd_ptr;
                        r_left   <= n_left;
                        r_vld    <= 1'b0;
                    end
                end
                S_RUN: begin
                    r_vld  <= rd_en;
                    r_vidx <= r_rd_ptr;
                    if (rd_en) begin
                        r_rd_ptr <= (r_job.op == OP_INSERT) ? r_rd_ptr - 1'b1
                                                            : r_rd_ptr + 1'b1;
                        r_left   <= r_left - 1'b1;
                    end
                    if (finish) begin
                        r_state <= S_IDLE;
                        r_vld   <= 1'b0;
                        r_left  <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.found_index   = r_out_found;
    assign o_rsp.read_value    = r_out_rd;
    assign o_rsp.element_count = r_out_count;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we && o_ram_re |-> o_ram_waddr != o_ram_raddr)
        else $error("RAM read and write hit the same entry in one cycle");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> !r_out_vld)
        else $error("response produced while the output register is occupied");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !o_ram_we && !o_ram_re)
        else $error("RAM access while the back end is idle");

endmodule

>>> rtl/core/positional_array_engine_core.sv
`timescale 1ns / 1ps
// Top level of the positional array engine: front end, job queue, back end and
// element RAM. Depends on pae_pkg, pae_if, pae_ram, pae_front, pae_fifo, pae_back.

// The engine keeps an ordered array of up to DEPTH signed 32-bit elements and
// answers every request with exactly one response. Insert places a value at a
// position from zero to the current count and moves later elements up; delete
// removes the element at a position below the count and moves later elements
// down; search reports the lowest index holding a value; read returns the
// element at a position. A position out of range gives an invalid status and
// leaves the array alone, and an insert into a full array reports full. The
// front end checks each request against its own running count in the cycle it
// is accepted and drops it into a two-entry queue, so requests keep flowing in
// while the back end is busy, until the queue is full. The back end works one
// request at a time and its cost is set by the single-read-port element RAM,
// which it walks one entry per cycle: an insert reads every element from the
// position to the end, a delete every element above the position, a search
// from index zero up to the first match, a read one element, and a rejected
// request none. Responses wait in an output register, and the back end starts
// its next request while that register is being emptied. The element RAM needs
// no clearing after reset, since no request can read an entry beyond the count.
module positional_array_engine_core import pae_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEFAULT,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int JOB_W = OP_W + STAT_W + AW + 2 * CW + DATA_W
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pae_cmd_if.sink   i_cmd,
    pae_rsp_if.source o_rsp
);

    // Front end to queue.
    logic             fq_valid;
    logic             fq_ready;
    logic [JOB_W-1:0] fq_job;

    // Queue to back end.
    logic             qb_valid;
    logic             qb_pop;
    logic [JOB_W-1:0] qb_job;

    // Back end to element RAM.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Classifies requests and tracks the element count as seen after every
    // accepted request.
    pae_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job)
    );

    // Short queue that lets the front end and the back end stall independently.
    pae_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_valid),
        .i_data  (fq_job),
        .o_ready (fq_ready),
        .o_valid (qb_valid),
        .i_pop   (qb_pop),
        .o_data  (qb_job)
    );

    // Carries out shifts, searches and reads against the element RAM.
    pae_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qb_valid),
        .o_job_pop   (qb_pop),
        .i_job       (qb_job),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_rsp       (o_rsp)
    );

    // Element storage; contents are undefined until written.
    pae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
